@@ design/md5bc_pkg.sv @@
// Package with the MD5 constants, tables and helper functions shared by the block.
`default_nettype none

package md5bc_pkg;

   // Standard MD5 initial chaining values.
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS      = 64;

   // Working or chaining words A B C D.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5bc_abcd_type;

   // Sine-derived additive constant of one round.
   function automatic logic [31:0] sine_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // Left-rotate amount, chosen by the phase and the round index modulo four.
   function automatic logic [4:0] rot_amount(input logic [5:0] idx);
      logic [4:0] r;
      unique case ({idx[5:4], idx[1:0]})
         4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
         4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
         4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
         4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Message word index of one round; all arithmetic is modulo sixteen.
   function automatic logic [3:0] msg_index(input logic [5:0] idx);
      logic [3:0] i4;
      logic [3:0] g;
      i4 = idx[3:0];
      unique case (idx[5:4])
         2'd0: g = i4;
         2'd1: g = 4'(i4 * 4'd5 + 4'd1);
         2'd2: g = 4'(i4 * 4'd3 + 4'd5);
         2'd3: g = 4'(i4 * 4'd7);
         default: g = i4;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

@@ design/md5bc_round.sv @@
// One MD5 round: the shared datapath that the sequencer steps through all 64 rounds.
`default_nettype none

module md5bc_round
   import md5bc_pkg::*;
(
   input  wire md5bc_abcd_type  cur,
   input  wire logic [5:0]      round_idx,
   input  wire logic [31:0]     msg_word,
   output md5bc_abcd_type       nxt
);

   logic [31:0] f_val;
   logic [31:0] sum;
   logic [63:0] rot_wide;
   logic [31:0] rot_val;

   // Round function of the current phase.
   always_comb begin
      unique case (round_idx[5:4])
         2'd0: f_val = (cur.b & cur.c) | (~cur.b & cur.d);
         2'd1: f_val = (cur.d & cur.b) | (~cur.d & cur.c);
         2'd2: f_val = cur.b ^ cur.c ^ cur.d;
         2'd3: f_val = cur.c ^ (cur.b | ~cur.d);
         default: f_val = cur.b ^ cur.c ^ cur.d;
      endcase
   end

   // Sum of the four terms, then rotate left by the table amount.
   assign sum      = f_val + cur.a + sine_k(round_idx) + msg_word;
   assign rot_wide = {sum, sum} << rot_amount(round_idx);
   assign rot_val  = rot_wide[63:32];

   // Shift the working words along.
   assign nxt.a = cur.d;
   assign nxt.b = cur.b + rot_val;
   assign nxt.c = cur.b;
   assign nxt.d = cur.c;

endmodule

`default_nettype wire

@@ design/md5_block_compression_top.sv @@
// Top level of the MD5 block compression: word buffer, round sequencer and digest register.
// After the sixteenth word of a block is accepted, the sequencer runs the rounds and then a
// finish step that registers the digest word; the finish step waits while the last one is pending.
// Throughput: one word per cycle while loading; no new words are taken during the rounds or
// the finish step, so the shared round unit works on one block at a time.
// Reset (synchronous, active high) loads the initial chaining values and clears the word count.
`default_nettype none

module md5_block_compression_top
   import md5bc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,   // [31:0] message_word
   input  wire logic          req_tuser,   // [0] new_message
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata    // [31:0] digest_a, [63:32] digest_b,
                                           // [95:64] digest_c, [127:96] digest_d
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [3:0]       word_count_ff, word_count_in;
   logic [5:0]       round_count_ff, round_count_in;
   md5bc_abcd_type   chain_ff, chain_in;
   md5bc_abcd_type   work_ff, work_in;
   md5bc_abcd_type   digest_ff, digest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      block_words_ff [BLOCK_WORDS];

   md5bc_abcd_type   round_next;
   md5bc_abcd_type   chain_sum;
   md5bc_abcd_type   iv;
   logic             accept;
   logic             out_free;
   logic [3:0]       wr_idx;

   assign iv         = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign wr_idx     = req_tuser ? 4'd0 : word_count_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {digest_ff.d, digest_ff.c, digest_ff.b, digest_ff.a};

   // Shared round datapath, fed from the block buffer at the scheduled index.
   md5bc_round u_round (
      .cur       (work_ff),
      .round_idx (round_count_ff),
      .msg_word  (block_words_ff[msg_index(round_count_ff)]),
      .nxt       (round_next)
   );

   // Final feed-forward into the chaining words.
   assign chain_sum.a = chain_ff.a + work_ff.a;
   assign chain_sum.b = chain_ff.b + work_ff.b;
   assign chain_sum.c = chain_ff.c + work_ff.c;
   assign chain_sum.d = chain_ff.d + work_ff.d;

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      word_count_in  = word_count_ff;
      round_count_in = round_count_ff;
      chain_in       = chain_ff;
      work_in        = work_ff;
      digest_in      = digest_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (req_tuser) begin
                  chain_in = iv;
               end
               word_count_in = wr_idx + 4'd1;
               if (wr_idx == 4'(BLOCK_WORDS - 1)) begin
                  state_in       = ST_ROUND;
                  round_count_in = '0;
                  work_in        = chain_ff;
               end
            end
         end
         ST_ROUND: begin
            work_in        = round_next;
            round_count_in = round_count_ff + 6'd1;
            if (round_count_ff == 6'(ROUNDS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               chain_in     = chain_sum;
               digest_in    = chain_sum;
               rsp_valid_in = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      digest_ff <= digest_in;
      if (reset) begin
         state_ff       <= ST_LOAD;
         word_count_ff  <= '0;
         round_count_ff <= '0;
         chain_ff       <= iv;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         word_count_ff  <= word_count_in;
         round_count_ff <= round_count_in;
         chain_ff       <= chain_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Block buffer: one word written per accepted word.
   always_ff @(posedge clock) begin
      if (accept) begin
         block_words_ff[wr_idx] <= req_tdata;
      end
   end

`ifndef NO_ASSERTIONS
   // The last word of a block starts the rounds from round zero.
   a_block_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (wr_idx == 4'(BLOCK_WORDS - 1))
      |=> (state_ff == ST_ROUND) && (round_count_ff == 6'd0))
      else $error("block did not start rounds");

   // After the last round the sequencer moves to the finish step.
   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (round_count_ff == 6'(ROUNDS - 1))
      |=> (state_ff == ST_FINISH))
      else $error("rounds did not end after the last round");

   // A finish with a free output register produces a digest word.
   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && out_free |=> rsp_valid_ff && (state_ff == ST_LOAD))
      else $error("finish did not emit a digest");

   // A pending digest is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(digest_ff))
      else $error("pending digest overwritten");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for md5_block_compression_top: stimulus, prediction and checking.
module testbench;
   import md5bc_pkg::*;

   localparam int unsigned WORD_TARGET    = 1550;
   localparam int unsigned IDLE_PCT       = 13;
   localparam int unsigned HOLDOFF_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES  = 100;

   // Round constants, round 0 in the top word.
   localparam logic [64*32-1:0] ROUND_K = {
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts indexed by {phase, round[1:0]}, entry 0 in the top bits.
   localparam logic [16*5-1:0] ROTATE_BY = {
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef struct packed {
      logic [31:0] word;
      logic        first;
      logic        hold;     // wait for every digest before offering this word
   } msg_word_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata  = '0;   // [31:0] message_word
   logic          req_tuser  = 1'b0; // [0] new_message
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;         // [31:0] digest_a, [63:32] digest_b,
                                     // [95:64] digest_c, [127:96] digest_d

   // Predictor state.
   logic [31:0]    block_buf [16];
   md5bc_abcd_type chain = {IV_A, IV_B, IV_C, IV_D};
   int unsigned    fill_count = 0;

   md5bc_abcd_type expected_digests [$];
   msg_word_type   word_queue [$];
   int unsigned    total_words = 0;
   int unsigned    words_accepted = 0;
   int unsigned    digests_seen = 0;
   int unsigned    holdoff_left = 0;
   bit             holdoff_done = 1'b0;
   int unsigned    error_count = 0;

   md5_block_compression_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Take one accepted message word; after sixteen words run the 64 rounds and queue the digest.
   task automatic absorb_word(input logic [31:0] word, input logic first);
      logic [31:0] a, b, c, d, f;
      logic [63:0] spun;
      logic [5:0]  ri;
      logic [3:0]  g;
      logic [4:0]  s;
      int          r;
      if (first) begin
         chain = {IV_A, IV_B, IV_C, IV_D};
         fill_count = 0;
      end
      block_buf[fill_count] = word;
      fill_count++;
      if (fill_count == 16) begin
         fill_count = 0;
         a = chain.a;
         b = chain.b;
         c = chain.c;
         d = chain.d;
         for (r = 0; r < 64; r++) begin
            ri = 6'(r);
            case (ri[5:4])
               2'd0: begin
                  f = (b & c) | (~b & d);
                  g = ri[3:0];
               end
               2'd1: begin
                  f = (d & b) | (~d & c);
                  g = 4'(ri * 5 + 1);
               end
               2'd2: begin
                  f = b ^ c ^ d;
                  g = 4'(ri * 3 + 5);
               end
               default: begin
                  f = c ^ (b | ~d);
                  g = 4'(ri * 7);
               end
            endcase
            s = ROTATE_BY[(15 - {ri[5:4], ri[1:0]}) * 5 +: 5];
            f = f + a + ROUND_K[(63 - r) * 32 +: 32] + block_buf[g];
            a = d;
            d = c;
            c = b;
            spun = {f, f} << s;
            b = b + spun[63:32];
         end
         chain.a = chain.a + a;
         chain.b = chain.b + b;
         chain.c = chain.c + c;
         chain.d = chain.d + d;
         expected_digests.push_back(chain);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s mismatch: expected %h, got %h", name, want, got);
      end
   endtask

   task automatic queue_word(input logic [31:0] word, input logic first, input logic hold);
      msg_word_type item;
      item.word  = word;
      item.first = first;
      item.hold  = hold;
      word_queue.push_back(item);
   endtask

   // Message content leaning on the extremes now and then.
   function automatic logic [31:0] random_word();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // Sender: offers queued words with random gaps and a calm stretch without any.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_word(req_tdata, req_tuser);
            words_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (word_queue.size() != 0
                && !(word_queue[0].hold && expected_digests.size() != 0)
                && ((words_accepted >= 300 && words_accepted < 500)
                    || $urandom_range(99) >= IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= word_queue[0].word;
               req_tuser  <= word_queue[0].first;
               void'(word_queue.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each digest word against the oldest prediction and drives backpressure.
   always @(posedge clock) begin
      md5bc_abcd_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            digests_seen++;
            if (expected_digests.size() == 0) begin
               error_count++;
               $error("digest word with no digest expected: %h", rsp_tdata);
            end else begin
               want = expected_digests.pop_front();
               check_field("digest_a", want.a, rsp_tdata[31:0]);
               check_field("digest_b", want.b, rsp_tdata[63:32]);
               check_field("digest_c", want.c, rsp_tdata[95:64]);
               check_field("digest_d", want.d, rsp_tdata[127:96]);
            end
         end
         // One long hold-off lets the block fill up and stall its input.
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (!holdoff_done && digests_seen == 12) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (digests_seen >= 40 && digests_seen < 56)
                          || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int unsigned pick;
      int unsigned nwords;
      int unsigned n;
      logic        lead_flag;
      logic        noisy;
      bit          hold;
      bit          hold_done;
      hold_done = 1'b0;

      // Padded "abc" block with no new-message flag: the chain starts from reset values.
      queue_word(32'h8063_6261, 1'b0, 1'b0);
      for (n = 1; n < 16; n++)
         queue_word((n == 14) ? 32'h0000_0018 : 32'h0000_0000, 1'b0, 1'b0);
      // A partial block with extreme words; the words that follow either complete it or drop it.
      queue_word(32'hffff_ffff, 1'b1, 1'b0);
      queue_word(32'h0000_0000, 1'b0, 1'b0);
      queue_word(32'hffff_ffff, 1'b0, 1'b0);

      // Mostly whole messages; some continuations, cut-off blocks and stray flags.
      while (word_queue.size() < WORD_TARGET) begin
         pick = $urandom_range(99);
         hold = !hold_done && word_queue.size() >= 800;
         hold_done = hold_done || hold;
         noisy = 1'b0;
         lead_flag = 1'b1;
         if (pick < 70) begin
            nwords = 16 * $urandom_range(1, 4);
         end else if (pick < 80) begin
            nwords = 16;
            lead_flag = 1'b0;
         end else if (pick < 90) begin
            nwords = $urandom_range(1, 15);
         end else begin
            nwords = $urandom_range(1, 20);
            noisy = 1'b1;
            lead_flag = ($urandom_range(7) == 0);
         end
         for (n = 0; n < nwords; n++)
            queue_word(random_word(),
                       (n == 0) ? lead_flag : (noisy && $urandom_range(7) == 0),
                       (n == 0) && hold);
      end
      total_words = word_queue.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted < total_words) @(posedge clock);
      while (expected_digests.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog.
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
design/md5bc_pkg.sv
design/md5bc_round.sv
design/md5_block_compression_top.sv
dv/testbench.sv
